// ===== design/tak_pkg.sv =====
// ----------------------------------------------------------------------------
// tak_pkg
// Shared types and constants for the tilt angle Kalman filter.
// ----------------------------------------------------------------------------
package tak_pkg;

	localparam int unsigned FRAC_SHIFT = 24;
	localparam int unsigned CFG_W      = 32;
	localparam int unsigned IO_W       = 32;

	typedef enum logic [1:0] {
		REG_QA  = 2'd0,
		REG_QB  = 2'd1,
		REG_R   = 2'd2,
		REG_DT  = 2'd3
	} reg_idx_t;

	localparam logic [CFG_W-1:0] QA_RESET = 32'd2516582;
	localparam logic [CFG_W-1:0] QB_RESET = 32'd16777;
	localparam logic [CFG_W-1:0] R_RESET  = 32'd83886080;
	localparam logic [CFG_W-1:0] DT_RESET = 32'd83886;

	// Datapath operations, one per controller step.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,       // latch input item, rate error = rate - bias
		OP_MUL_RATE,   // product = rate_err * dt
		OP_ANG_PRED,   // angle += product ; pd0 = qa - p01 - p10
		OP_MUL_PD0,    // product = pd0 * dt
		OP_P00_PRED,
		OP_MUL_P11,    // product = -p11 * dt
		OP_P01_PRED,   // p01 += product, p10 += product
		OP_MUL_QB,
		OP_P11_PRED,   // p11 += product ; err ; e = r + p00
		OP_DIV_K0,     // start k0 = p00 / e
		OP_DIV_K1,     // store k0, start k1 = p10 / e
		OP_K1_STORE,
		OP_MUL_K0P00,
		OP_UPD_P00,    // t0/t1 retained in tmp registers
		OP_MUL_K0P01,
		OP_UPD_P01,
		OP_MUL_K1P00,
		OP_UPD_P10,
		OP_MUL_K1P01,
		OP_UPD_P11,
		OP_MUL_K0ERR,
		OP_UPD_ANG,
		OP_MUL_K1ERR,
		OP_UPD_BIAS
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   mul_start;
		logic   div_start;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} dp_sts_t;

endpackage

// ===== design/tak_mul.sv =====
// ----------------------------------------------------------------------------
// tak_mul
// Sequenced signed Q-format multiplier: four 32x32 partial products of the
// magnitudes, then round half away from zero, shift by the fraction and
// saturate to the datapath width.
// ----------------------------------------------------------------------------
module tak_mul #(
	parameter int unsigned W  = 32,
	parameter int unsigned AW = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic signed [AW-1:0] b,
	output logic                 done,
	output logic signed [W-1:0]  y
);
	import tak_pkg::*;

	localparam int unsigned HW = 32;
	localparam int unsigned PW = 4 * HW;

	logic [2*HW-1:0]   ua_q, ub_q;
	logic              neg_q;
	logic [PW-1:0]     acc_q;
	logic [2:0]        step_q;
	logic              busy_q;
	logic              fin_q;
	logic [2*HW-1:0]   pp;
	logic [HW-1:0]     pa, pb;
	logic [PW-1:0]     rnd;
	logic [PW-1:0]     shf;
	logic signed [W:0] mag_lim;
	logic              ovf;
	logic [W-1:0]      max_pos;

	always_comb begin
		unique case (step_q[1:0])
			2'd0: begin pa = ua_q[HW-1:0];     pb = ub_q[HW-1:0];     end
			2'd1: begin pa = ua_q[HW-1:0];     pb = ub_q[2*HW-1:HW];  end
			2'd2: begin pa = ua_q[2*HW-1:HW];  pb = ub_q[HW-1:0];     end
			default: begin pa = ua_q[2*HW-1:HW]; pb = ub_q[2*HW-1:HW]; end
		endcase
		pp = pa * pb;
	end

	assign rnd = acc_q + (PW'(1) << (FRAC_SHIFT - 1));
	assign shf = rnd >> FRAC_SHIFT;
	assign max_pos = {1'b0, {(W-1){1'b1}}};
	// Magnitude above W-1 bits saturates, except exactly 2^(W-1) when negative.
	assign ovf = neg_q ? (shf > PW'({1'b1, {(W-1){1'b0}}})) : (shf > PW'(max_pos));
	assign mag_lim = ovf ? (neg_q ? $signed({2'b01, {(W-1){1'b0}}})
	                              : $signed({1'b0, max_pos}))
	                     : $signed({1'b0, shf[W-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= (2*HW)'(a[AW-1] ? -$signed({a[AW-1], a}) : $signed({a[AW-1], a}));
			ub_q  <= (2*HW)'(b[AW-1] ? -$signed({b[AW-1], b}) : $signed({b[AW-1], b}));
			neg_q <= a[AW-1] ^ b[AW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			unique case (step_q[1:0])
				2'd0:    acc_q <= acc_q + PW'(pp);
				2'd1:    acc_q <= acc_q + (PW'(pp) << HW);
				2'd2:    acc_q <= acc_q + (PW'(pp) << HW);
				default: acc_q <= acc_q + (PW'(pp) << (2*HW));
			endcase
		end
		if (fin_q) begin
			y <= W'(neg_q ? -mag_lim : mag_lim);
		end
	end

	assign done = fin_q;
endmodule

// ===== design/tak_div.sv =====
// ----------------------------------------------------------------------------
// tak_div
// Radix-2 restoring divider giving (n << 24) / d truncated toward zero and
// saturated; a zero divisor gives zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tak_div #(
	parameter int unsigned W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] n,
	input  logic signed [W-1:0] d,
	output logic                done,
	output logic signed [W-1:0] y
);
	import tak_pkg::*;

	localparam int unsigned NW = W + FRAC_SHIFT;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  den_q;
	logic [NW-1:0] quo_q;
	logic          neg_q, zero_q, busy_q, fin_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic [W-1:0]  max_pos;
	logic          ovf;
	logic [W:0]    mag_lim;

	assign trial = {rem_q[W-1:0], num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign max_pos = {1'b0, {(W-1){1'b1}}};
	assign ovf = neg_q ? (quo_q > NW'({1'b1, {(W-1){1'b0}}})) : (quo_q > NW'(max_pos));
	assign mag_lim = ovf ? (neg_q ? {2'b01, {(W-1){1'b0}}} : {1'b0, max_pos})
	                     : {1'b0, quo_q[W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {W'(n[W-1] ? -$signed({n[W-1], n}) : $signed({n[W-1], n})),
			           {FRAC_SHIFT{1'b0}}};
			den_q  <= W'(d[W-1] ? -$signed({d[W-1], d}) : $signed({d[W-1], d}));
			neg_q  <= n[W-1] ^ d[W-1];
			zero_q <= (d == '0);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
		if (fin_q) begin
			y <= zero_q ? '0 : W'(neg_q ? -mag_lim : mag_lim);
		end
	end

	assign done = fin_q;
endmodule

// ===== design/tak_datapath.sv =====
// ----------------------------------------------------------------------------
// tak_datapath
// Filter state, configuration registers, saturating adder and the shared
// multiplier and divider, driven one operation at a time by the controller.
// ----------------------------------------------------------------------------
module tak_datapath #(
	parameter int unsigned W = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tak_pkg::dp_cmd_t              cmd,
	output tak_pkg::dp_sts_t              sts,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_sel,
	input  logic [tak_pkg::CFG_W-1:0]     cfg_data,
	input  logic signed [tak_pkg::IO_W-1:0] in_angle,
	input  logic signed [tak_pkg::IO_W-1:0] in_rate,
	output logic signed [tak_pkg::IO_W-1:0] out_angle,
	output logic signed [tak_pkg::IO_W-1:0] out_rate,
	output logic signed [tak_pkg::IO_W-1:0] out_bias
);
	import tak_pkg::*;

	// Multiplier operands carry the unsigned tuning values without clipping.
	localparam int unsigned MW = ((W > CFG_W) ? W : CFG_W) + 1;
	localparam int unsigned XW = MW + 2;
	localparam logic signed [W-1:0] P_INIT = (W > FRAC_SHIFT + 1) ?
	                                         W'(64'd1 << FRAC_SHIFT) :
	                                         {1'b0, {(W-1){1'b1}}};

	logic [CFG_W-1:0] qa_q, qb_q, r_q, dt_q;
	logic signed [W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [W-1:0] mang_q, mrate_q, tmp_q, err_q, e_q, k0_q, k1_q, t0_q, t1_q;
	logic signed [MW-1:0] ma, mb;
	logic signed [W-1:0] my, dn, dy;
	logic signed [W-1:0] sa, sb, ssum;
	logic                ssub;
	logic signed [W+1:0] wide;
	logic signed [W-1:0] smax, smin;
	logic signed [XW-1:0] pd0_w, e_w;

	assign smax = {1'b0, {(W-1){1'b1}}};
	assign smin = {1'b1, {(W-1){1'b0}}};

	function automatic logic signed [MW-1:0] sx(input logic signed [W-1:0] v);
		return MW'(v);
	endfunction

	function automatic logic signed [MW-1:0] zx(input logic [CFG_W-1:0] v);
		return $signed({{(MW-CFG_W){1'b0}}, v});
	endfunction

	function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
		if (v > XW'(smax)) return smax;
		if (v < XW'(smin)) return smin;
		return W'(v);
	endfunction

	function automatic logic signed [W-1:0] in_ext(input logic signed [IO_W-1:0] v);
		logic signed [W+IO_W-1:0] t;
		t = (W+IO_W)'(v);
		if (t > (W+IO_W)'(smax)) return smax;
		if (t < (W+IO_W)'(smin)) return smin;
		return W'(t);
	endfunction

	function automatic logic signed [IO_W-1:0] out_sat(input logic signed [W+1:0] v);
		logic signed [W+IO_W+1:0] t;
		t = (W+IO_W+2)'(v);
		if (t > (W+IO_W+2)'($signed({1'b0, {(IO_W-1){1'b1}}}))) return {1'b0, {(IO_W-1){1'b1}}};
		if (t < (W+IO_W+2)'($signed({1'b1, {(IO_W-1){1'b0}}}))) return {1'b1, {(IO_W-1){1'b0}}};
		return IO_W'(t);
	endfunction

	// Both sums are formed in full before a single saturation.
	assign pd0_w = $signed({{(XW-CFG_W){1'b0}}, qa_q}) - XW'(p01_q) - XW'(p10_q);
	assign e_w   = $signed({{(XW-CFG_W){1'b0}}, r_q}) + XW'(p00_q);

	// One shared saturating adder serves the load, the p00/p01/p11 predictions and every update step.
	always_comb begin
		sa = ang_q; sb = my; ssub = 1'b0;
		unique case (cmd.op)
			OP_LOAD:     begin sa = in_ext(in_rate); sb = bias_q; ssub = 1'b1; end
			OP_P00_PRED: begin sa = p00_q; sb = my; end
			OP_P01_PRED: begin sa = p01_q; sb = my; end
			OP_P11_PRED: begin sa = p11_q; sb = my; end
			OP_UPD_P00:  begin sa = p00_q; sb = my; ssub = 1'b1; end
			OP_UPD_P01:  begin sa = p01_q; sb = my; ssub = 1'b1; end
			OP_UPD_P10:  begin sa = p10_q; sb = my; ssub = 1'b1; end
			OP_UPD_P11:  begin sa = p11_q; sb = my; ssub = 1'b1; end
			OP_UPD_ANG:  begin sa = ang_q; sb = my; end
			OP_UPD_BIAS: begin sa = bias_q; sb = my; end
			default:     begin sa = ang_q; sb = my; end
		endcase
		wide = ssub ? ({{2{sa[W-1]}}, sa} - {{2{sb[W-1]}}, sb})
		            : ({{2{sa[W-1]}}, sa} + {{2{sb[W-1]}}, sb});
		if (wide > (W+2)'(smax))      ssum = smax;
		else if (wide < (W+2)'(smin)) ssum = smin;
		else                          ssum = W'(wide);
	end

	function automatic logic signed [W-1:0] sat2(input logic signed [W-1:0] a,
	                                             input logic signed [W-1:0] b,
	                                             input logic sub);
		logic signed [W+1:0] t;
		t = sub ? ({{2{a[W-1]}}, a} - {{2{b[W-1]}}, b}) : ({{2{a[W-1]}}, a} + {{2{b[W-1]}}, b});
		if (t > (W+2)'(smax)) return smax;
		if (t < (W+2)'(smin)) return smin;
		return W'(t);
	endfunction

	always_comb begin
		ma = sx(tmp_q); mb = zx(dt_q);
		unique case (cmd.op)
			OP_MUL_RATE:  begin ma = sx(tmp_q);        mb = zx(dt_q); end
			OP_MUL_PD0:   begin ma = sx(tmp_q);        mb = zx(dt_q); end
			OP_MUL_P11:   begin ma = -sx(p11_q);       mb = zx(dt_q); end
			OP_MUL_QB:    begin ma = zx(qb_q);         mb = zx(dt_q); end
			OP_MUL_K0P00: begin ma = sx(k0_q);         mb = sx(t0_q); end
			OP_MUL_K0P01: begin ma = sx(k0_q);         mb = sx(t1_q); end
			OP_MUL_K1P00: begin ma = sx(k1_q);         mb = sx(t0_q); end
			OP_MUL_K1P01: begin ma = sx(k1_q);         mb = sx(t1_q); end
			OP_MUL_K0ERR: begin ma = sx(k0_q);         mb = sx(err_q); end
			OP_MUL_K1ERR: begin ma = sx(k1_q);         mb = sx(err_q); end
			default:      begin ma = sx(tmp_q);        mb = zx(dt_q); end
		endcase
		dn = (cmd.op == OP_DIV_K1) ? p10_q : p00_q;
	end

	tak_mul #(.W(W), .AW(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start),
		.a(ma), .b(mb), .done(sts.mul_done), .y(my)
	);

	tak_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.n(dn), .d(e_q), .done(sts.div_done), .y(dy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= QA_RESET;
			qb_q <= QB_RESET;
			r_q  <= R_RESET;
			dt_q <= DT_RESET;
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= P_INIT;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= P_INIT;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_sel))
					REG_QA: qa_q <= cfg_data;
					REG_QB: qb_q <= cfg_data;
					REG_R:  r_q  <= cfg_data;
					REG_DT: dt_q <= cfg_data;
				endcase
			end
			unique case (cmd.op)
				OP_ANG_PRED: ang_q  <= sat2(ang_q, my, 1'b0);
				OP_P00_PRED: p00_q  <= ssum;
				OP_P01_PRED: begin
					p01_q <= ssum;
					p10_q <= sat2(p10_q, my, 1'b0);
				end
				OP_P11_PRED: p11_q  <= ssum;
				OP_UPD_P00:  p00_q  <= ssum;
				OP_UPD_P01:  p01_q  <= ssum;
				OP_UPD_P10:  p10_q  <= ssum;
				OP_UPD_P11:  p11_q  <= ssum;
				OP_UPD_ANG:  ang_q  <= ssum;
				OP_UPD_BIAS: bias_q <= ssum;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				mang_q  <= in_ext(in_angle);
				mrate_q <= in_ext(in_rate);
				tmp_q   <= ssum;
			end
			OP_ANG_PRED: tmp_q <= sat_x(pd0_w);
			OP_P11_PRED: begin
				err_q <= sat2(mang_q, ang_q, 1'b1);
				e_q   <= sat_x(e_w);
			end
			OP_DIV_K1:   k0_q <= dy;
			OP_K1_STORE: begin
				k1_q <= dy;
				t0_q <= p00_q;
				t1_q <= p01_q;
			end
			default: ;
		endcase
	end

	assign out_angle = out_sat((W+2)'(ang_q));
	assign out_bias  = out_sat((W+2)'(bias_q));
	assign out_rate  = out_sat({{2{mrate_q[W-1]}}, mrate_q} - {{2{bias_q[W-1]}}, bias_q});
endmodule

// ===== design/tak_ctrl.sv =====
// ----------------------------------------------------------------------------
// tak_ctrl
// Sequencer for one filter update: walks the datapath through prediction,
// gain division and correction, then holds the result for the output side.
// ----------------------------------------------------------------------------
module tak_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_fire,
	input  tak_pkg::dp_sts_t sts,
	output tak_pkg::dp_cmd_t cmd,
	output logic             busy,
	output logic             out_full
);
	import tak_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t state_q;
	dp_op_t op_q;
	logic   full_q;
	logic   mstart_q, dstart_q;

	function automatic logic is_mul(input dp_op_t o);
		return o == OP_MUL_RATE || o == OP_MUL_PD0 || o == OP_MUL_P11 ||
		       o == OP_MUL_QB || o == OP_MUL_K0P00 || o == OP_MUL_K0P01 ||
		       o == OP_MUL_K1P00 || o == OP_MUL_K1P01 || o == OP_MUL_K0ERR ||
		       o == OP_MUL_K1ERR;
	endfunction

	// The op stays on the command bus while a unit runs so operand muxes hold.
	// The item is latched at the edge that accepts it.
	always_comb begin
		if (state_q == ST_IDLE)
			cmd.op = in_fire ? OP_LOAD : OP_NONE;
		else if (state_q == ST_DONE)
			cmd.op = OP_NONE;
		else
			cmd.op = op_q;
		cmd.mul_start = mstart_q;
		cmd.div_start = dstart_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_NONE;
			full_q   <= 1'b0;
			mstart_q <= 1'b0;
			dstart_q <= 1'b0;
		end else begin
			mstart_q <= 1'b0;
			dstart_q <= 1'b0;
			if (out_fire) full_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q    <= OP_MUL_RATE;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (is_mul(op_q)) begin
						mstart_q <= 1'b1;
						state_q  <= ST_WAIT;
					end else if (op_q == OP_DIV_K0 || op_q == OP_DIV_K1) begin
						dstart_q <= 1'b1;
						state_q  <= ST_WAIT;
					end else if (op_q == OP_UPD_BIAS) begin
						state_q <= ST_DONE;
					end else begin
						op_q <= dp_op_t'(op_q + 5'd1);
					end
				end
				ST_WAIT: begin
					if ((is_mul(op_q) && sts.mul_done) || (!is_mul(op_q) && sts.div_done)) begin
						op_q    <= dp_op_t'(op_q + 5'd1);
						state_q <= ST_ISSUE;
					end
				end
				ST_DONE: begin
					full_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE) || full_q;
	assign out_full = full_q;
endmodule

// ===== design/tilt_angle_kalman_filter_top.sv =====
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter_top
// Two-state (angle, gyro bias) Kalman filter on fixed-point samples.
//
//  channel | signals                                  | direction
//  in      | in_valid in_ready measured_angle/rate    | to block
//  out     | out_valid out_ready filtered_angle ...   | from block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | to block
//
// Each item passes through ten multiplies in the shared multiplier, two
// divides of DATA_WIDTH + 24 quotient bits each in the divider, eleven
// adder and store steps, and a step that presents the result. One item is
// worked at a time; the next is taken the cycle after the result has been
// taken. Reset restores the default tuning and the initial covariance at
// once. A stalled output holds.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter_top #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] measured_rate,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] filtered_angle,
	output logic signed [31:0] corrected_rate,
	output logic signed [31:0] bias_estimate,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import tak_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    busy, full, in_fire, out_fire, cfg_we;

	assign in_ready  = !busy;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = full;
	assign out_fire  = out_valid && out_ready;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && (cfg_index < 32'd4);

	tak_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .busy(busy), .out_full(full)
	);

	tak_datapath #(.W(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_sel(cfg_index[1:0]), .cfg_data(cfg_data),
		.in_angle(measured_angle), .in_rate(measured_rate),
		.out_angle(filtered_angle), .out_rate(corrected_rate),
		.out_bias(bias_estimate)
	);

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("item accepted while result pending");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(filtered_angle) && $stable(bias_estimate))
		else $error("result changed while stalled");
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready) else $error("ready after accept");
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt angle Kalman filter. Samples are pushed
// through the input channel in random bursts while the output stalls on its
// own pattern; a bit-exact fixed-point predictor supplies the expected
// angle, corrected rate and bias for every accepted sample.
// ----------------------------------------------------------------------------
module tb_top;
	import tak_pkg::*;

	localparam int DW = 32;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1750;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
		logic signed [31:0] bias;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] measured_angle = '0;
	logic signed [31:0] measured_rate = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] filtered_angle, corrected_rate, bias_estimate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	tilt_angle_kalman_filter_top #(.DATA_WIDTH(DW)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.measured_angle(measured_angle), .measured_rate(measured_rate),
		.out_valid(out_valid), .out_ready(out_ready),
		.filtered_angle(filtered_angle), .corrected_rate(corrected_rate),
		.bias_estimate(bias_estimate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state and tuning.
	logic [31:0] tune_qa, tune_qb, tune_r, tune_dt;
	longint est_angle, est_bias, p00, p01, p10, p11;

	sample_t   sample_q[$];
	estimate_t estimate_q[$];
	int        error_count = 0;
	int        results_seen = 0;
	int        samples_sent = 0;
	int        idle_cycles = 0;
	bit        timed_out = 1'b0;

	function automatic longint sat_bits(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint clip(longint v);
		return sat_bits(v, DW);
	endfunction

	// Product of two Q values, shifted by the fraction width, rounded half
	// away from zero; the 128-bit magnitude keeps every case exact.
	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] pm;
		logic [63:0] ma, mb, res;
		logic neg;
		ma = a < 0 ? 64'(-a) : 64'(a);
		mb = b < 0 ? 64'(-b) : 64'(b);
		neg = (a < 0) != (b < 0);
		pm = ({64'd0, ma} * {64'd0, mb}) + (128'd1 << (FRAC_SHIFT - 1));
		pm = pm >> FRAC_SHIFT;
		if (pm > (128'd1 << 62)) res = 64'd1 << 62;
		else res = pm[63:0];
		return clip(neg ? -longint'(res) : longint'(res));
	endfunction

	function automatic longint fx_div(longint n, longint d);
		logic [63:0] un, ud, q;
		logic neg;
		if (d == 0) return 0;
		un = n < 0 ? 64'(-n) : 64'(n);
		ud = d < 0 ? 64'(-d) : 64'(d);
		neg = (n < 0) != (d < 0);
		q = un / ud;
		if (q >= (64'd1 << (62 - FRAC_SHIFT))) q = 64'd1 << 62;
		else q = ((un << FRAC_SHIFT) / ud);
		return clip(neg ? -longint'(q) : longint'(q));
	endfunction

	function automatic void filter_reset();
		tune_qa = QA_RESET; tune_qb = QB_RESET;
		tune_r = R_RESET;   tune_dt = DT_RESET;
		est_angle = 0; est_bias = 0;
		p00 = clip(longint'(1) << FRAC_SHIFT); p01 = 0; p10 = 0;
		p11 = clip(longint'(1) << FRAC_SHIFT);
	endfunction

	function automatic estimate_t filter_update(sample_t s);
		longint ma, mr, dt, pd0, innov, e, k0, k1, t0, t1;
		estimate_t r;
		ma = clip(longint'(s.angle));
		mr = clip(longint'(s.rate));
		dt = longint'(tune_dt);
		est_angle = clip(est_angle + fx_mul(clip(mr - est_bias), dt));
		pd0 = clip(longint'(tune_qa) - p01 - p10);
		p00 = clip(p00 + fx_mul(pd0, dt));
		p01 = clip(p01 + fx_mul(-p11, dt));
		p10 = clip(p10 + fx_mul(-p11, dt));
		p11 = clip(p11 + fx_mul(longint'(tune_qb), dt));
		innov = clip(ma - est_angle);
		e = clip(longint'(tune_r) + p00);
		k0 = fx_div(p00, e);
		k1 = fx_div(p10, e);
		t0 = p00; t1 = p01;
		p00 = clip(p00 - fx_mul(k0, t0));
		p01 = clip(p01 - fx_mul(k0, t1));
		p10 = clip(p10 - fx_mul(k1, t0));
		p11 = clip(p11 - fx_mul(k1, t1));
		est_angle = clip(est_angle + fx_mul(k0, innov));
		est_bias = clip(est_bias + fx_mul(k1, innov));
		r.angle = 32'(sat_bits(est_angle, 32));
		r.rate = 32'(sat_bits(mr - est_bias, 32));
		r.bias = 32'(sat_bits(est_bias, 32));
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
		error_count++;
	endtask

	// Driver: bursts of back-to-back samples separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			estimate_q.push_back(filter_update({measured_angle, measured_rate}));
			samples_sent++;
		end
		if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (sample_q.size() > 0 && arst_n) begin
				sample_t s;
				s = sample_q.pop_front();
				measured_angle <= s.angle;
				measured_rate <= s.rate;
				in_valid <= 1'b1;
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 6);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor and output stall pattern.
	int stall_phase = 0;
	always @(posedge clk) begin
		estimate_t want;
		if (out_valid && out_ready) begin
			if (estimate_q.size() == 0) begin
				$display("unexpected result %0d", results_seen);
				error_count++;
			end else begin
				want = estimate_q.pop_front();
				if (filtered_angle !== want.angle)
					report_mismatch("filtered_angle", filtered_angle, want.angle);
				if (corrected_rate !== want.rate)
					report_mismatch("corrected_rate", corrected_rate, want.rate);
				if (bias_estimate !== want.bias)
					report_mismatch("bias_estimate", bias_estimate, want.bias);
			end
			results_seen++;
		end
		stall_phase <= (stall_phase + 1) % 97;
		if (stall_phase < 40) out_ready <= 1'b1;
		else if (stall_phase < 60) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 2) != 0);
	end

	// Watchdog.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("watchdog expired with %0d results outstanding", estimate_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_index <= 32'(idx);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_QA: tune_qa = value;
			REG_QB: tune_qb = value;
			REG_R: tune_r = value;
			REG_DT: tune_dt = value;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (sample_q.size() > 0 || in_valid || estimate_q.size() > 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Noisy angle near a base, small rate near zero, edge words mixed in.
	task automatic queue_trace(int n, bit wild);
		sample_t s;
		int base;
		base = $urandom_range(0, 60) - 30;
		for (int i = 0; i < n; i++) begin
			if (wild || $urandom_range(0, 9) == 0) begin
				s.angle = edge_word();
				s.rate = edge_word();
			end else begin
				s.angle = 32'((base << 16) + int'($urandom_range(0, 1 << 18)) - (1 << 17));
				s.rate = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			end
			sample_q.push_back(s);
		end
	endtask

	initial begin
		sample_t s;
		filter_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners under default tuning.
		s = '{32'sh7fff_ffff, 32'sh7fff_ffff}; sample_q.push_back(s);
		s = '{32'sh8000_0000, 32'sh8000_0000}; sample_q.push_back(s);
		s = '{32'sh0, 32'sh0};                 sample_q.push_back(s);
		s = '{32'sh8000_0000, 32'sh7fff_ffff}; sample_q.push_back(s);
		s = '{32'sh7fff_ffff, 32'sh8000_0000}; sample_q.push_back(s);
		s = '{32'shffff_ffff, 32'sh0000_0001}; sample_q.push_back(s);
		s = '{32'sh5555_5555, 32'shaaaa_aaaa}; sample_q.push_back(s);
		s = '{32'shaaaa_aaaa, 32'sh5555_5555}; sample_q.push_back(s);
		wait_idle();

		// Extreme tuning: smallest R and dt, then the largest values, which
		// also hold the innovation variance at its maximum and saturate products.
		write_reg(REG_R, 32'd1);
		write_reg(REG_DT, 32'd1);
		write_reg(REG_QA, 32'd0);
		write_reg(REG_QB, 32'd0);
		queue_trace(6, 1'b1);
		wait_idle();
		write_reg(REG_R, 32'hffff_ffff);
		write_reg(REG_DT, 32'hffff_ffff);
		write_reg(REG_QA, 32'hffff_ffff);
		write_reg(REG_QB, 32'hffff_ffff);
		queue_trace(6, 1'b1);
		wait_idle();

		// Random phases with fresh tuning each time.
		for (int ph = 0; ph < 14; ph++) begin
			if (ph == 0) begin
				write_reg(REG_QA, QA_RESET); write_reg(REG_QB, QB_RESET);
				write_reg(REG_R, R_RESET);   write_reg(REG_DT, DT_RESET);
			end else if (ph % 4 == 3) begin
				write_reg(REG_QA, $urandom); write_reg(REG_QB, $urandom);
				write_reg(REG_R, $urandom_range(1, 32'hffff_ffff));
				write_reg(REG_DT, $urandom_range(1, 32'hffff_ffff));
			end else begin
				write_reg(REG_QA, $urandom_range(0, 1 << 25));
				write_reg(REG_QB, $urandom_range(0, 1 << 16));
				write_reg(REG_R, $urandom_range(1, 1 << 28));
				write_reg(REG_DT, $urandom_range(1, 1 << 20));
			end
			queue_trace(N_RANDOM / 14, ph % 4 == 3);
			wait_idle();
		end

		$display("sent %0d samples, checked %0d estimates across 17 tuning phases",
			samples_sent, results_seen);
		if (error_count == 0 && estimate_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
